/* hdl/assert_macros.svh */
// Assertion macros shared by the median filter RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a boolean expression at every clock edge outside reset.
`define SWM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Check a temporal property at every clock edge outside reset.
`define SWM_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

/* hdl/swm_pkg.sv */
// Shared types and constants for the sliding window median filter.
// No dependencies; imported by the cell, the sorter and the top level.
package swm_pkg;

  // Default sizing of the window store and the sample word
  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Configuration register width and reset value
  localparam int               CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd1;

  // Operation broadcast to every sorter cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_INSERT = 2'd2
  } swm_op_e;

endpackage

/* hdl/swm_cell.sv */
// One cell of the sorted store: holds one sample and trades it with neighbors.
// Depends on swm_pkg for the operation code.
module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CW           = 7,
  parameter int INDEX        = 0
) (
  input  logic                    clk_i,
  input  swm_op_e                 op_i,
  input  logic [SAMPLE_WIDTH-1:0] key_i,
  input  logic [CW-1:0]           occ_i,
  input  logic [SAMPLE_WIDTH-1:0] left_val_i,
  input  logic                    left_gt_i,
  input  logic [SAMPLE_WIDTH-1:0] right_val_i,
  input  logic                    right_gt_i,
  output logic [SAMPLE_WIDTH-1:0] val_o,
  output logic                    gt_o
);

  localparam logic [CW-1:0] Idx = CW'(INDEX);

  logic [SAMPLE_WIDTH-1:0] val_q, val_d;

  // Unoccupied cells act as larger than any key
  assign gt_o  = (Idx >= occ_i) || ($signed(val_q) > $signed(key_i));
  assign val_o = val_q;

  // Shift left on remove, shift right and drop the key in on insert
  always_comb begin
    val_d = val_q;
    case (op_i)
      OP_REMOVE: begin
        if (right_gt_i) val_d = right_val_i;
      end
      OP_INSERT: begin
        if (gt_o) val_d = left_gt_i ? left_val_i : key_i;
      end
      default: val_d = val_q;
    endcase
  end

  // Hold the sample; payload needs no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

/* hdl/swm_sorter.sv */
// Row of sorter cells holding the window in ascending order, plus rank select.
// Depends on swm_pkg and swm_cell.
module swm_sorter import swm_pkg::*; #(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CW           = 7,
  parameter int IW           = 6
) (
  input  logic                    clk_i,
  input  swm_op_e                 op_i,
  input  logic [SAMPLE_WIDTH-1:0] key_i,
  input  logic [CW-1:0]           occ_i,
  input  logic [IW-1:0]           rank_i,
  output logic [SAMPLE_WIDTH-1:0] median_o
);

  logic [SAMPLE_WIDTH-1:0] cell_val [WINDOW_MAX];
  logic                    cell_gt  [WINDOW_MAX];

  // Build the chain; the ends see a smaller-than-all left and a larger right
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] lval, rval;
    logic                    lgt, rgt;
    if (i == 0) begin : g_first
      assign lval = cell_val[i];
      assign lgt  = 1'b0;
    end else begin : g_mid_l
      assign lval = cell_val[i-1];
      assign lgt  = cell_gt[i-1];
    end
    if (i == WINDOW_MAX - 1) begin : g_last
      assign rval = cell_val[i];
      assign rgt  = 1'b1;
    end else begin : g_mid_r
      assign rval = cell_val[i+1];
      assign rgt  = cell_gt[i+1];
    end
    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .CW           (CW),
      .INDEX        (i)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op_i),
      .key_i       (key_i),
      .occ_i       (occ_i),
      .left_val_i  (lval),
      .left_gt_i   (lgt),
      .right_val_i (rval),
      .right_gt_i  (rgt),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // Select the cell of the requested rank
  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (rank_i == IW'(i)) median_o = cell_val[i];
    end
  end

endmodule

/* hdl/sliding_window_median.sv */
// Sliding window median filter, top level.
// Channels: sample_* input (valid/ready), median_* output (valid/ready),
// cfg_* write of the window_size register (always ready). A register write
// empties the window; issue it only while the block is idle.
// Each accepted sample goes into a ring memory and into a row of sorter
// cells kept in ascending order. Until window_size samples have arrived no
// median comes out; after that every sample yields the lower median.
// Steps: while the window fills, a sample takes an insert pass, followed
// by an output load when it completes the window. Once full, a sample takes
// a ring read, a remove pass through the cell row, an insert pass and an
// output load. A new sample is taken only once the block is back in idle
// after these steps. Reset empties the window and sets window_size to 1; no
// clearing pass is needed. A stalled receiver holds the output register; the
// next sample is still taken and its result waits in the output load step.
// Depends on swm_pkg, swm_sorter, swm_cell and assert_macros.svh.
`include "assert_macros.svh"
module sliding_window_median import swm_pkg::*; #(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_WIDTH-1:0]    cfg_window_size_i,
  input  logic                    sample_valid_i,
  output logic                    sample_ready_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                    median_valid_o,
  input  logic                    median_ready_i,
  output logic [SAMPLE_WIDTH-1:0] median_o
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REMOVE = 2'd1;
  localparam logic [1:0] ST_INSERT = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [CFG_WIDTH-1:0]    ws_q;
  logic [CW-1:0]           w_eff;
  logic [EW-1:0]           ws_ext;
  logic [1:0]              state_q, state_d;
  logic [CW-1:0]           fill_q, fill_d;
  logic [CW-1:0]           occ_q;
  logic [IW-1:0]           ptr_q, ptr_d;
  logic                    emit_q;
  logic [SAMPLE_WIDTH-1:0] key_q;
  logic [SAMPLE_WIDTH-1:0] ring_mem [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] ring_rd_q;
  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] median_q;
  logic [SAMPLE_WIDTH-1:0] sorter_median;
  logic [IW-1:0]           rank;
  logic                    in_xfer, cfg_xfer, out_xfer, load_out, full;
  swm_op_e                 op;
  logic [SAMPLE_WIDTH-1:0] op_key;
  logic [CW-1:0]           op_occ;

  assign cfg_ready_o    = 1'b1;
  assign sample_ready_o = (state_q == ST_IDLE);
  assign median_valid_o = out_valid_q;
  assign median_o       = median_q;

  assign cfg_xfer = cfg_valid_i;
  assign in_xfer  = sample_valid_i && sample_ready_o;
  assign out_xfer = out_valid_q && median_ready_i;
  assign load_out = (state_q == ST_EMIT) && (!out_valid_q || median_ready_i);

  // Clamp the window size into 1..WINDOW_MAX
  assign ws_ext = EW'(ws_q);
  always_comb begin
    if (ws_q == '0) begin
      w_eff = CW'(1);
    end else if (ws_ext > EW'(WINDOW_MAX)) begin
      w_eff = CW'(WINDOW_MAX);
    end else begin
      w_eff = CW'(ws_ext);
    end
  end

  assign full = (fill_q == w_eff);
  assign rank = IW'((w_eff - CW'(1)) >> 1);

  // Sequence remove, insert and output load
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    ptr_d   = ptr_q;
    if (in_xfer) begin
      ptr_d = (CW'(ptr_q) + CW'(1) == w_eff) ? '0 : ptr_q + IW'(1);
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (full) begin
            state_d = ST_REMOVE;
          end else begin
            state_d = ST_INSERT;
            fill_d  = fill_q + CW'(1);
          end
        end
      end
      ST_REMOVE: state_d = ST_INSERT;
      ST_INSERT: state_d = emit_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_xfer) begin
      fill_d = '0;
      ptr_d  = '0;
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      ptr_q       <= '0;
      ws_q        <= WINDOW_SIZE_RESET;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ptr_q   <= ptr_d;
      if (cfg_xfer) ws_q <= cfg_window_size_i;
      if (in_xfer) emit_q <= full || (fill_q + CW'(1) == w_eff);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the item payload, the insert occupancy and the output result
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q <= sample_i;
      occ_q <= full ? (w_eff - CW'(1)) : fill_q;
    end
    if (load_out) median_q <= sorter_median;
  end

  // Ring memory: read the oldest sample, then overwrite its slot
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ring_rd_q       <= ring_mem[ptr_q];
      ring_mem[ptr_q] <= sample_i;
    end
  end

  // Drive the cell row
  always_comb begin
    op     = OP_HOLD;
    op_key = key_q;
    op_occ = occ_q;
    unique case (state_q)
      ST_REMOVE: begin
        op     = OP_REMOVE;
        op_key = ring_rd_q;
        op_occ = w_eff;
      end
      ST_INSERT: op = OP_INSERT;
      default:   op = OP_HOLD;
    endcase
  end

  swm_sorter #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CW           (CW),
    .IW           (IW)
  ) u_sorter (
    .clk_i    (clk_i),
    .op_i     (op),
    .key_i    (op_key),
    .occ_i    (op_occ),
    .rank_i   (rank),
    .median_o (sorter_median)
  );

  // Checks on fill bookkeeping and sequencing
  `SWM_ASSERT_ALWAYS(a_fill_bound, fill_q <= w_eff, "fill count exceeds window size")
  `SWM_ASSERT_ALWAYS(a_ptr_bound, CW'(ptr_q) < w_eff, "ring pointer outside window")
  `SWM_ASSERT_PROP(a_full_removes, (in_xfer && full) |=> (state_q == ST_REMOVE),
    "full window transfer did not start a remove pass")
  `SWM_ASSERT_PROP(a_load_from_emit, $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT),
    "result appeared outside the output load step")

endmodule
